/* sv/pscs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_pkg
// Shared types, constants and the seven-segment decode for the pulse counter
// with multiplexed display scan.
// ----------------------------------------------------------------------------
package pscs_pkg;

   // Field widths
   localparam int CountWidth = 16;
   localparam int CsrIdxWidth = 8;
   localparam int CsrDataWidth = 16;
   localparam int BcdDigits = 4;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [3:0] bcd_digit_type;
   typedef logic [7:0] seg_type;
   typedef logic [3:0] enable_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   // Register indexes
   localparam csr_idx_type CSR_WINDOW_LOW = csr_idx_type'(0);
   localparam csr_idx_type CSR_WINDOW_HIGH = csr_idx_type'(1);

   // Reset values of the window registers
   localparam count_type WindowLowReset = count_type'(10);
   localparam count_type WindowHighReset = count_type'(20);

   // Count at and above which the display shows the overflow pattern
   localparam count_type OverflowLimit = count_type'(9999);
   localparam seg_type OverflowPattern = 8'hDC;
   localparam enable_type AllDigitsOff = 4'hF;

   // Control from the counter to the display scan
   typedef struct packed {
      logic advance;   // request moves into the result register
      logic bump;      // rising edge counted this request
      logic wrap;      // binary count wraps to zero
      logic over;      // updated count is in overflow
      logic tick;      // refresh one digit
   } disp_ctl_type;

   // Display values for the result register
   typedef struct packed {
      enable_type enable;
      seg_type segments;
   } disp_out_type;

   // Decimal digit to segments a..g in bits 0..6, dot off
   function automatic seg_type seg_pattern(bcd_digit_type digit);
      seg_type pat;
      case (digit)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5B;
         4'd3: pat = 8'h4F;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6D;
         4'd6: pat = 8'h7D;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

/* sv/pscs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pscs_req_if;
   logic valid;
   logic ready;
   logic pulse_level;
   logic scan_tick;

   modport source (output valid, output pulse_level, output scan_tick, input ready);
   modport sink (input valid, input pulse_level, input scan_tick, output ready);
endinterface

interface pscs_rsp_if;
   logic valid;
   logic ready;
   logic [3:0] digit_enable;
   logic [7:0] segments;
   logic in_window;
   logic overflow_flag;

   modport source (output valid, output digit_enable, output segments,
                   output in_window, output overflow_flag, input ready);
   modport sink (input valid, input digit_enable, input segments,
                 input in_window, input overflow_flag, output ready);
endinterface

interface pscs_csr_if;
   logic valid;
   logic ready;
   logic [7:0] index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/pscs_display.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscs_display
// Decimal shadow counter and digit scan: keeps a BCD copy of the count,
// steps the digit index on scan ticks and produces the next enable/segment values.
// ----------------------------------------------------------------------------
module pscs_display #(
   parameter int DIGITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pscs_pkg::disp_ctl_type ctl,
   output pscs_pkg::disp_out_type disp
);
   import pscs_pkg::*;

   localparam logic [1:0] LastPos = 2'(DIGITS - 1);

   bcd_digit_type bcd_ff [BcdDigits];
   bcd_digit_type bcd_in [BcdDigits];
   logic [1:0] idx_ff, idx_in;
   seg_type seg_ff, seg_in;
   enable_type en_ff, en_in;

   // BCD increment in step with the binary count; cleared when it wraps.
   // Valid for every count below the overflow limit.
   always_comb begin
      logic carry;
      carry = ctl.bump;
      for (int i = 0; i < BcdDigits; i++) begin
         if (ctl.wrap) begin
            bcd_in[i] = '0;
         end else if (carry && bcd_ff[i] == 4'd9) begin
            bcd_in[i] = '0;
         end else begin
            bcd_in[i] = bcd_ff[i] + {3'b000, carry};
            carry = 1'b0;
         end
      end
   end

   // Digit refresh on a scan tick, taken from the updated count
   always_comb begin
      idx_in = idx_ff;
      seg_in = seg_ff;
      en_in = en_ff;
      if (ctl.tick) begin
         en_in = enable_type'(~(4'b0001 << idx_ff));
         seg_in = ctl.over ? OverflowPattern : seg_pattern(bcd_in[idx_ff]);
         idx_in = (idx_ff == LastPos) ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         seg_ff <= '0;
         en_ff <= AllDigitsOff;
         for (int i = 0; i < BcdDigits; i++) begin
            bcd_ff[i] <= '0;
         end
      end else if (ctl.advance) begin
         idx_ff <= idx_in;
         seg_ff <= seg_in;
         en_ff <= en_in;
         for (int i = 0; i < BcdDigits; i++) begin
            bcd_ff[i] <= bcd_in[i];
         end
      end
   end

   assign disp.enable = en_in;
   assign disp.segments = seg_in;

endmodule

/* sv/pulse_counter_seven_segment_scan_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_counter_seven_segment_scan_unit
// Counts rising edges of a sampled pulse level, flags overflow and a count
// window, and scans a multiplexed seven-segment display one digit per tick.
//
//   channel  dir  fields                                          handshake
//   req_ch   in   pulse_level, scan_tick                          valid/ready
//   rsp_ch   out  digit_enable, segments, in_window, overflow_flag valid/ready
//   csr_ch   in   index (0 window_low, 1 window_high), data        valid/ready
//
// One request per cycle while responses are taken; requests pass the input
// register, then the result register. All work for a request is one
// combinational pass. Synchronous reset: count, edge history and digit index
// clear, all digits off, window 10..20. No clearing pass.
// A stalled response holds its register; the input register still takes one
// more request, then req ready drops until the response is taken.
// ----------------------------------------------------------------------------
module pulse_counter_seven_segment_scan_unit #(
   parameter int DIGITS = 4
) (
   input  logic              clock,
   input  logic              reset,
   pscs_req_if.sink          req_ch,
   pscs_rsp_if.source        rsp_ch,
   pscs_csr_if.sink          csr_ch
);
   import pscs_pkg::*;

   // Input register
   logic s0_valid_ff, s0_valid_in;
   logic s0_level_ff, s0_tick_ff;

   // Counter state and window registers
   count_type count_ff, count_in;
   logic last_level_ff;
   count_type win_low_ff, win_high_ff;

   // Result register
   logic out_valid_ff, out_valid_in;
   disp_out_type out_disp_ff;
   logic out_win_ff, out_over_ff;

   logic advance;
   logic rise;
   logic over;
   logic inwin;
   disp_ctl_type disp_ctl;
   disp_out_type disp_next;

   // Handshake
   assign advance = s0_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s0_valid_ff || advance;
   assign s0_valid_in = (req_ch.valid && req_ch.ready) || (s0_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);
   assign csr_ch.ready = 1'b1;

   // Edge detect, count update and flags on the updated count
   assign rise = s0_level_ff && !last_level_ff;
   assign count_in = count_ff + count_type'(rise);
   assign over = count_in >= OverflowLimit;
   assign inwin = (count_in >= win_low_ff) && (count_in <= win_high_ff);

   assign disp_ctl.advance = advance;
   assign disp_ctl.bump = rise;
   assign disp_ctl.wrap = rise && (count_ff == '1);
   assign disp_ctl.over = over;
   assign disp_ctl.tick = s0_tick_ff;

   pscs_display #(
      .DIGITS (DIGITS)
   ) u_display (
      .clock (clock),
      .reset (reset),
      .ctl   (disp_ctl),
      .disp  (disp_next)
   );

   // Control and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff <= '0;
         last_level_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            count_ff <= count_in;
            last_level_ff <= s0_level_ff;
         end
      end
   end

   // Window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff <= WindowLowReset;
         win_high_ff <= WindowHighReset;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_WINDOW_LOW:  win_low_ff <= count_type'(csr_ch.data);
            CSR_WINDOW_HIGH: win_high_ff <= count_type'(csr_ch.data);
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s0_level_ff <= req_ch.pulse_level;
         s0_tick_ff <= req_ch.scan_tick;
      end
      if (advance) begin
         out_disp_ff <= disp_next;
         out_win_ff <= inwin;
         out_over_ff <= over;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.digit_enable = out_disp_ff.enable;
   assign rsp_ch.segments = out_disp_ff.segments;
   assign rsp_ch.in_window = out_win_ff;
   assign rsp_ch.overflow_flag = out_over_ff;

endmodule
